// ===== design/mpk_pkg.sv =====
// ============================================================================
// mpk_pkg
// Shared types, widths and helper functions for the k-transaction profit chain.
// ============================================================================
package mpk_pkg;

  localparam int CELL_W   = 34;  // cell balances, two's complement
  localparam int CALC_W   = 36;  // headroom for balance +/- price
  localparam int LANE_P_W = 32;  // price as carried down the chain
  localparam int PROFIT_W = 32;
  localparam int TRANS_W  = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // register index, taken from paddr[2]
  localparam logic REG_TRANSACTIONS = 1'b0;

  localparam logic [CELL_W-1:0] CELL_MIN = {1'b1, {(CELL_W-1){1'b0}}};
  localparam logic [CELL_W-1:0] CELL_MAX = {1'b0, {(CELL_W-1){1'b1}}};

  // one word as it travels from cell to cell
  typedef struct packed {
    logic [LANE_P_W-1:0] price;
    logic                last;
    logic [CELL_W-1:0]   base;    // updated sold balance of the previous cell
    logic [PROFIT_W-1:0] profit;  // set by the cell that ends the chain in use
  } word_t;

  // clamp a widened sum back to the cell range
  function automatic logic signed [CELL_W-1:0] sat_cell(input logic signed [CALC_W-1:0] v);
    logic signed [CALC_W-1:0] lo;
    logic signed [CALC_W-1:0] hi;
    lo = CALC_W'($signed(CELL_MIN));
    hi = CALC_W'($signed(CELL_MAX));
    if (v < lo) begin
      sat_cell = $signed(CELL_MIN);
    end else if (v > hi) begin
      sat_cell = $signed(CELL_MAX);
    end else begin
      sat_cell = v[CELL_W-1:0];
    end
  endfunction

  // map a cell balance to the reported profit: negative reads as zero
  function automatic logic [PROFIT_W-1:0] sat_profit(input logic signed [CELL_W-1:0] v);
    if (v[CELL_W-1]) begin
      sat_profit = '0;
    end else if (v[CELL_W-2:PROFIT_W] != '0) begin
      sat_profit = '1;
    end else begin
      sat_profit = v[PROFIT_W-1:0];
    end
  endfunction

endpackage

// ===== design/mpk_stream_if.sv =====
// ============================================================================
// mpk stream interfaces
// Valid/ready channels for price words in and profit words out.
// ============================================================================
interface mpk_in_if #(
  parameter int PRICE_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;
  logic                  last;

  modport source (output valid, price, last, input ready);
  modport sink   (input valid, price, last, output ready);
endinterface

interface mpk_out_if ();
  logic                          valid;
  logic                          ready;
  logic [mpk_pkg::PROFIT_W-1:0]  profit;
  logic                          final_res;

  modport source (output valid, profit, final_res, input ready);
  modport sink   (input valid, profit, final_res, output ready);
endinterface

// ===== design/mpk_cfg.sv =====
// ============================================================================
// mpk_cfg
// APB register block holding the transaction count.
// ============================================================================
module mpk_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpk_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mpk_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mpk_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [mpk_pkg::TRANS_W-1:0]    transactions
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      transactions <= mpk_pkg::TRANS_W'(1);
    end else if (wr_en && (paddr[2] == mpk_pkg::REG_TRANSACTIONS)) begin
      transactions <= pwdata[mpk_pkg::TRANS_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == mpk_pkg::REG_TRANSACTIONS) begin
      prdata = mpk_pkg::APB_DATA_W'(transactions);
    end else begin
      prdata = '0;
    end
  end

endmodule

// ===== design/mpk_cell.sv =====
// ============================================================================
// mpk_cell
// One transaction of the chain: best holding and sold balances.
// ============================================================================
module mpk_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,       // whole chain moves this cycle
  input  logic           active,    // transaction index below the limit
  input  logic           tap,       // last transaction in use
  input  logic           in_valid,
  input  mpk_pkg::word_t in_word,
  output logic           out_valid,
  output mpk_pkg::word_t out_word
);

  logic signed [mpk_pkg::CELL_W-1:0] holding;
  logic signed [mpk_pkg::CELL_W-1:0] sold;
  logic signed [mpk_pkg::CELL_W-1:0] holding_next;
  logic signed [mpk_pkg::CELL_W-1:0] sold_next;
  logic signed [mpk_pkg::CELL_W-1:0] buy;
  logic signed [mpk_pkg::CELL_W-1:0] sell;
  logic signed [mpk_pkg::CALC_W-1:0] p_ext;
  logic signed [mpk_pkg::CALC_W-1:0] base_ext;
  logic signed [mpk_pkg::CALC_W-1:0] h_ext;
  mpk_pkg::word_t                    word_next;

  always_comb begin
    p_ext    = $signed(mpk_pkg::CALC_W'(in_word.price));
    base_ext = mpk_pkg::CALC_W'($signed(in_word.base));
    buy      = mpk_pkg::sat_cell(base_ext - p_ext);
    holding_next = (active && (buy > holding)) ? buy : holding;
    h_ext    = mpk_pkg::CALC_W'(holding_next);
    sell     = mpk_pkg::sat_cell(h_ext + p_ext);
    sold_next = (active && (sell > sold)) ? sell : sold;

    word_next        = in_word;
    word_next.base   = sold_next;
    word_next.profit = tap ? mpk_pkg::sat_profit(sold_next) : in_word.profit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding   <= $signed(mpk_pkg::CELL_MIN);
      sold      <= $signed(mpk_pkg::CELL_MIN);
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
      if (in_valid) begin
        // end of sequence: drop back to unreachable
        if (in_word.last) begin
          holding <= $signed(mpk_pkg::CELL_MIN);
          sold    <= $signed(mpk_pkg::CELL_MIN);
        end else begin
          holding <= holding_next;
          sold    <= sold_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= word_next;
    end
  end

endmodule

// ===== design/max_profit_k_transactions_stream_top.sv =====
// ============================================================================
// max_profit_k_transactions_stream_top
// Streaming best profit with at most k buy-sell transactions.
// ============================================================================
// The block takes one price word per clock and returns one profit word per
// price, in order, once it has passed all MAX_TRANSACTIONS cells. The
// rate is set by the row of MAX_TRANSACTIONS transaction cells: a price
// enters cell 0 and moves one cell per cycle, so cell j sees the sold balance
// that cell j-1 produced for the same price, and a new price can follow
// right behind it. When the output word is not taken, the
// whole row holds and prices.ready drops. The transactions register (APB
// byte address 0, reset value 1) limits how many cells take part; values
// above MAX_TRANSACTIONS act as MAX_TRANSACTIONS, and 0 reports a profit of
// 0. A price marked last clears every cell as it passes, so the next
// sequence starts fresh. Write the register only while no word is in flight.
// ============================================================================
module max_profit_k_transactions_stream_top #(
  parameter int MAX_TRANSACTIONS = 16,
  parameter int PRICE_BITS       = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpk_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mpk_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mpk_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  mpk_in_if.sink                         prices,
  mpk_out_if.source                      results
);

  // largest limit the 5-bit register can express after clamping
  localparam logic [mpk_pkg::TRANS_W-1:0] MAX_K =
    (MAX_TRANSACTIONS >= (1 << mpk_pkg::TRANS_W) - 1) ?
      {mpk_pkg::TRANS_W{1'b1}} : mpk_pkg::TRANS_W'(MAX_TRANSACTIONS);

  logic [mpk_pkg::TRANS_W-1:0] transactions;
  logic [mpk_pkg::TRANS_W-1:0] k_eff;
  logic                        adv;
  mpk_pkg::word_t              head;

  logic           cell_valid [MAX_TRANSACTIONS];
  mpk_pkg::word_t cell_word  [MAX_TRANSACTIONS];

  mpk_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .transactions (transactions)
  );

  assign k_eff = (transactions > MAX_K) ? MAX_K : transactions;

  // The row advances whenever the final cell's word can move on.
  assign adv          = !cell_valid[MAX_TRANSACTIONS-1] || results.ready;
  assign prices.ready = adv && !rst;

  // Word entering cell 0: no earlier transaction, so the base balance is 0.
  always_comb begin
    head        = '0;
    head.price  = mpk_pkg::LANE_P_W'(prices.price[PRICE_BITS-1:0]);
    head.last   = prices.last;
    head.base   = '0;
    head.profit = '0;
  end

  for (genvar j = 0; j < MAX_TRANSACTIONS; j++) begin : g_cell
    logic           act;
    logic           tap;
    logic           v_in;
    mpk_pkg::word_t w_in;

    assign act = (j < int'(k_eff));
    assign tap = ((j + 1) == int'(k_eff));

    if (j == 0) begin : g_first
      assign v_in = prices.valid && !rst;
      assign w_in = head;
    end else begin : g_rest
      assign v_in = cell_valid[j-1];
      assign w_in = cell_word[j-1];
    end

    mpk_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .active    (act),
      .tap       (tap),
      .in_valid  (v_in),
      .in_word   (w_in),
      .out_valid (cell_valid[j]),
      .out_word  (cell_word[j])
    );
  end

  // The final cell's register doubles as the output register.
  assign results.valid     = cell_valid[MAX_TRANSACTIONS-1];
  assign results.profit    = cell_word[MAX_TRANSACTIONS-1].profit;
  assign results.final_res = cell_word[MAX_TRANSACTIONS-1].last;

endmodule

// ===== design/mpk_checker.sv =====
// ============================================================================
// mpk_checker
// Port-level checks on the profit chain, bound to the top level.
// ============================================================================
module mpk_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [mpk_pkg::APB_ADDR_W-1:0] paddr,
  input logic [mpk_pkg::APB_DATA_W-1:0] pwdata,
  input logic [mpk_pkg::APB_DATA_W-1:0] prdata,
  input logic                           pready,
  input logic                           in_ready,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [mpk_pkg::PROFIT_W-1:0]   res_profit
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word valid right after reset");

  // a stalled output freezes the whole row, so no price may enter
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !in_ready)
    else $error("price accepted while output stalled");

  // a stalled result word holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_profit)))
    else $error("stalled result word changed");

  // register read back reflects the last write
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && (paddr[2] == mpk_pkg::REG_TRANSACTIONS))
    |=> ((paddr[2] != mpk_pkg::REG_TRANSACTIONS) ||
         (prdata == mpk_pkg::APB_DATA_W'($past(pwdata[mpk_pkg::TRANS_W-1:0])))))
    else $error("transactions register read back mismatch");

endmodule

bind max_profit_k_transactions_stream_top mpk_checker u_mpk_checker (
  .clk        (clk),
  .rst        (rst),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata),
  .pready     (pready),
  .in_ready   (prices.ready),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .res_profit (results.profit)
);
